FILE: rtl/hda_pkg.sv
package hda_pkg;

   // payload widths of the channels
   localparam int HANDLE_W = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 17;

   // default pool capacity
   localparam int POOL_SIZE_DEF = 256;

   // command codes (the fourth code behaves as a check)
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HD = 2'd2;

   // one result beat
   typedef struct packed {
      logic [HANDLE_W-1:0] handle_out;
      logic [STATUS_W-1:0] status;
      logic                is_live;
      logic [COUNT_W-1:0]  live_count;
   } hda_rsp_type;

endpackage

FILE: rtl/hda_if.sv
interface hda_req_if;
   import hda_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [HANDLE_W-1:0] handle_in;

   modport source (output valid, output cmd, output handle_in, input ready);
   modport sink   (input valid, input cmd, input handle_in, output ready);
endinterface

interface hda_rsp_if;
   import hda_pkg::*;

   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] handle_out;
   logic [STATUS_W-1:0] status;
   logic                is_live;
   logic [COUNT_W-1:0]  live_count;

   modport source (output valid, output handle_out, output status, output is_live,
                   output live_count, input ready);
   modport sink   (input valid, input handle_out, input status, input is_live,
                   input live_count, output ready);
endinterface

FILE: rtl/hda_ram.sv
module hda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/hda_rsp_stage.sv
module hda_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hda_pkg::hda_rsp_type data,
   output logic                free,
   hda_rsp_if.source           rsp_bus
);
   import hda_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   hda_rsp_type data_ff;

   // slot can take a new beat when empty or being drained
   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.handle_out = data_ff.handle_out;
   assign rsp_bus.status     = data_ff.status;
   assign rsp_bus.is_live    = data_ff.is_live;
   assign rsp_bus.live_count = data_ff.live_count;
endmodule

FILE: rtl/dense_handle_allocator_core.sv
// sequence: allocate passes LOOK and DONE, check passes LOOK, VERIFY and DONE, and free
// passes LOOK, VERIFY, FIX and DONE (a bad free skips FIX); both map memories read registered
// throughput: one request in flight at a time; a new request is taken only in IDLE
// reset: synchronous; after reset a sweep over every slot loads identity handles and
// zero slots into the maps, requests are held off until it ends
module dense_handle_allocator_core #(
   parameter int POOL_SIZE = hda_pkg::POOL_SIZE_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hda_req_if.sink   req_bus,
   hda_rsp_if.source rsp_bus
);
   import hda_pkg::*;

   localparam int SW = $clog2(POOL_SIZE);
   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam logic [COUNT_W-1:0] POOL_LIM = COUNT_W'(POOL_SIZE);
   localparam logic [SW-1:0]      LAST_IDX = SW'(POOL_SIZE - 1);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOK   = 6'b000100,
      ST_VERIFY = 6'b001000,
      ST_FIX    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [SW-1:0]       clr_ff, clr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [HANDLE_W-1:0] h_ff, h_in;
   logic                in_range_ff, in_range_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [SW-1:0]       moved_ff, moved_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_live_ff, res_live_in;

   logic          s2h_we, h2s_we;
   logic [SW-1:0] s2h_waddr, s2h_wdata, s2h_raddr, s2h_rdata;
   logic [SW-1:0] h2s_waddr, h2s_wdata, h2s_raddr, h2s_rdata;

   logic          rsp_free, rsp_load;
   hda_rsp_type   rsp_data;
   logic [SW-1:0] last_slot;
   logic          is_full;
   logic          found;

   // dense array: slot -> handle
   hda_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_slot_to_handle (
      .clock   (clock),
      .wr_en   (s2h_we),
      .wr_addr (s2h_waddr),
      .wr_data (s2h_wdata),
      .rd_addr (s2h_raddr),
      .rd_data (s2h_rdata)
   );

   // reverse map: handle -> slot
   hda_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_handle_to_slot (
      .clock   (clock),
      .wr_en   (h2s_we),
      .wr_addr (h2s_waddr),
      .wr_data (h2s_wdata),
      .rd_addr (h2s_raddr),
      .rd_data (h2s_rdata)
   );

   hda_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (rsp_load),
      .data    (rsp_data),
      .free    (rsp_free),
      .rsp_bus (rsp_bus)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign last_slot = SW'(count_ff - CW'(1));
   assign is_full   = (count_ff == CW'(POOL_SIZE));
   // handle sits in a live slot and the dense array points back at it
   assign found     = in_range_ff && (CW'(slot_ff) < count_ff) &&
                      (s2h_rdata == h_ff[SW-1:0]);

   assign rsp_data.handle_out = res_handle_ff;
   assign rsp_data.status     = res_status_ff;
   assign rsp_data.is_live    = res_live_ff;
   assign rsp_data.live_count = COUNT_W'(count_ff);

   // sequencer: read, check, write back the maps
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      h_in          = h_ff;
      in_range_in   = in_range_ff;
      slot_in       = slot_ff;
      moved_in      = moved_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      res_live_in   = res_live_ff;
      s2h_we        = 1'b0;
      s2h_waddr     = '0;
      s2h_wdata     = '0;
      s2h_raddr     = '0;
      h2s_we        = 1'b0;
      h2s_waddr     = '0;
      h2s_wdata     = '0;
      h2s_raddr     = '0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // load identity handles and zero slots
            s2h_we    = 1'b1;
            s2h_waddr = clr_ff;
            s2h_wdata = clr_ff;
            h2s_we    = 1'b1;
            h2s_waddr = clr_ff;
            h2s_wdata = '0;
            clr_in    = clr_ff + SW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            h2s_raddr = req_bus.handle_in[SW-1:0];
            s2h_raddr = (req_bus.cmd == CMD_ALLOC) ? SW'(count_ff) : last_slot;
            if (req_bus.valid) begin
               cmd_in      = req_bus.cmd;
               h_in        = req_bus.handle_in;
               in_range_in = ({1'b0, req_bus.handle_in} < POOL_LIM);
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // slot of the handle, and handle at the head or tail slot
            slot_in   = h2s_rdata;
            moved_in  = s2h_rdata;
            s2h_raddr = h2s_rdata;
            if (cmd_ff == CMD_ALLOC) begin
               if (is_full) begin
                  res_handle_in = '0;
                  res_status_in = STATUS_FULL;
                  res_live_in   = 1'b0;
               end else begin
                  h2s_we        = 1'b1;
                  h2s_waddr     = s2h_rdata;
                  h2s_wdata     = SW'(count_ff);
                  count_in      = count_ff + CW'(1);
                  res_handle_in = HANDLE_W'(s2h_rdata);
                  res_status_in = STATUS_OK;
                  res_live_in   = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_VERIFY;
            end
         end
         ST_VERIFY: begin
            res_handle_in = h_ff;
            res_status_in = STATUS_OK;
            res_live_in   = 1'b0;
            state_in      = ST_DONE;
            if (cmd_ff == CMD_FREE) begin
               if (found) begin
                  // freed handle to the tail, tail handle takes its slot
                  s2h_we    = 1'b1;
                  s2h_waddr = last_slot;
                  s2h_wdata = h_ff[SW-1:0];
                  h2s_we    = 1'b1;
                  h2s_waddr = moved_ff;
                  h2s_wdata = slot_ff;
                  state_in  = ST_FIX;
               end else begin
                  res_status_in = STATUS_BAD_HD;
               end
            end else begin
               res_live_in = found;
            end
         end
         ST_FIX: begin
            s2h_we    = 1'b1;
            s2h_waddr = slot_ff;
            s2h_wdata = moved_ff;
            count_in  = count_ff - CW'(1);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            clr_in   = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   // request and result holding registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      h_ff          <= h_in;
      in_range_ff   <= in_range_in;
      slot_ff       <= slot_in;
      moved_ff      <= moved_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      res_live_ff   <= res_live_in;
   end

   // live count stays within the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(POOL_SIZE))
      else $error("live count exceeds pool size");

   // a successful allocate grows the count by one
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) && (cmd_ff == CMD_ALLOC) && !is_full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("allocate did not bump live count");

   // completing a free shrinks the count by one
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("free did not drop live count");

   // a free only commits on a live handle with a nonzero count
   a_free_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> in_range_ff && (count_ff != '0))
      else $error("free committed on a dead handle");

   // the response slot is loaded only when it can take the beat
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free && (state_ff == ST_DONE))
      else $error("response loaded over a pending beat");
endmodule

FILE: verif/tb_dense_handle_allocator_core.sv
module tb_dense_handle_allocator_core;
   import hda_pkg::*;

   localparam int POOL       = POOL_SIZE_DEF;
   localparam int SLOT_W     = $clog2(POOL);
   localparam int ITEMS      = 1600;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 400;
   localparam int CYCLE_CAP  = 400000;

   // the fourth selector code, which the block treats as a check
   localparam logic [CMD_W-1:0] CMD_CHECK_ALT = 2'd3;

   typedef enum {PH_FILL, PH_EMPTY, PH_MIX} phase_kind_type;

   // shadow of the sparse set: dense slot array, reverse map and live count
   class handle_pool_shadow;
      logic [SLOT_W-1:0] slot_handle [POOL];
      logic [SLOT_W-1:0] handle_slot [POOL];
      logic [SLOT_W:0]   live_total;
      hda_rsp_type       expected_rsp [$];
      int                fail_count;

      function new();
         for (int i = 0; i < POOL; i++) begin
            slot_handle[i] = SLOT_W'(i);
            handle_slot[i] = '0;
         end
         live_total = '0;
         fail_count = 0;
      endfunction

      function bit handle_is_live(logic [HANDLE_W-1:0] h);
         logic [SLOT_W-1:0] s;
         if (h >= POOL) return 1'b0;
         s = handle_slot[h[SLOT_W-1:0]];
         if (s >= live_total) return 1'b0;
         return slot_handle[s] == h[SLOT_W-1:0];
      endfunction

      // pick a handle: mostly live ones, else free, out of range or edge values
      function logic [HANDLE_W-1:0] pick_handle(int live_pct);
         int r;
         r = $urandom_range(0, 99);
         if (r < live_pct && live_total != 0)
            return HANDLE_W'(slot_handle[$urandom_range(0, int'(live_total) - 1)]);
         if (r < live_pct + (100 - live_pct) / 2)
            return HANDLE_W'($urandom_range(0, POOL - 1));
         case ($urandom_range(0, 5))
            0: return '0;
            1: return HANDLE_W'(POOL - 1);
            2: return HANDLE_W'(POOL);
            3: return '1;
            default: return HANDLE_W'($urandom_range(0, 65535));
         endcase
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h);
         hda_rsp_type       r;
         logic [SLOT_W-1:0] s;
         logic [SLOT_W-1:0] last;
         logic [SLOT_W-1:0] moved;
         r.handle_out = h;
         r.status     = STATUS_OK;
         r.is_live    = 1'b0;
         case (c)
            CMD_ALLOC: begin
               if (live_total >= POOL) begin
                  r.status     = STATUS_FULL;
                  r.handle_out = '0;
               end else begin
                  s = live_total[SLOT_W-1:0];
                  handle_slot[slot_handle[s]] = s;
                  r.handle_out = HANDLE_W'(slot_handle[s]);
                  r.is_live    = 1'b1;
                  live_total   = live_total + 1'b1;
               end
            end
            CMD_FREE: begin
               if (!handle_is_live(h)) begin
                  r.status = STATUS_BAD_HD;
               end else begin
                  // swap the freed handle with the last live one
                  s     = handle_slot[h[SLOT_W-1:0]];
                  last  = SLOT_W'(live_total - 1'b1);
                  moved = slot_handle[last];
                  live_total        = live_total - 1'b1;
                  slot_handle[last] = h[SLOT_W-1:0];
                  handle_slot[moved] = s;
                  slot_handle[s]    = moved;
               end
            end
            default: begin
               r.is_live = handle_is_live(h);
            end
         endcase
         r.live_count = COUNT_W'(live_total);
         expected_rsp.push_back(r);
      endfunction

      function void check_response(hda_rsp_type got);
         hda_rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result beat with nothing expected: handle_out %0d", got.handle_out);
            fail_count++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.handle_out !== want.handle_out) begin
            $error("handle_out: expected %0d, got %0d", want.handle_out, got.handle_out);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
         if (got.is_live !== want.is_live) begin
            $error("is_live: expected %0d, got %0d", want.is_live, got.is_live);
            fail_count++;
         end
         if (got.live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   hda_req_if req_bus ();
   hda_rsp_if rsp_bus ();

   handle_pool_shadow pool_shadow = new();

   int sent_count = 0;
   int burst_left = 0;
   bit hold_go    = 1'b0;

   dense_handle_allocator_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // response monitor
   always @(posedge clock) begin
      hda_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.handle_out = rsp_bus.handle_out;
         got.status     = rsp_bus.status;
         got.is_live    = rsp_bus.is_live;
         got.live_count = rsp_bus.live_count;
         pool_shadow.check_response(got);
      end
   end

   // receiver stall pattern, with one long hold-off once the sender asks for it
   initial begin
      int mode;
      int run_len;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_go && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // one request beat, held until accepted
   task automatic send_item(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= c;
      req_bus.handle_in <= h;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pool_shadow.note_request(c, h);
      sent_count++;
      if (sent_count == HOLD_AT) hold_go = 1'b1;
   endtask

   // sender bursts with random gaps between them
   task automatic paced_send(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      send_item(c, h);
      burst_left--;
   endtask

   // sender stops until every outstanding response is back
   task automatic wait_all_results();
      if (req_bus.valid) req_bus.valid <= 1'b0;
      while (pool_shadow.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // random request with the given mix of allocate and free, the rest checks
   task automatic random_request(input int alloc_pct, input int free_pct, input int live_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
         paced_send(CMD_ALLOC, HANDLE_W'($urandom_range(0, 65535)));
      else if (r < alloc_pct + free_pct)
         paced_send(CMD_FREE, pool_shadow.pick_handle(live_pct));
      else
         paced_send(($urandom_range(0, 5) == 0) ? CMD_CHECK_ALT : CMD_CHECK,
                    pool_shadow.pick_handle(live_pct));
   endtask

   // stimulus
   initial begin
      phase_kind_type kind;
      int             extra;
      int             len;
      int             alloc_pct;
      bit             first_phase;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_CHECK;
      req_bus.handle_in <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, bad frees, out of range, swap-on-free, double free
      send_item(CMD_CHECK, 16'd0);
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_FREE, 16'hFFFF);
      send_item(CMD_CHECK, 16'hFFFF);
      send_item(CMD_CHECK_ALT, 16'hAAAA);
      send_item(CMD_ALLOC, 16'h5555);
      send_item(CMD_CHECK, 16'd0);
      send_item(CMD_ALLOC, 16'hFFFF);
      send_item(CMD_ALLOC, 16'd0);
      send_item(CMD_FREE, 16'd1);
      send_item(CMD_CHECK, 16'd1);
      send_item(CMD_CHECK, 16'd2);
      send_item(CMD_FREE, 16'd2);
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_ALLOC, 16'd0);
      send_item(CMD_CHECK, 16'(POOL));
      send_item(CMD_FREE, 16'(POOL));
      send_item(CMD_CHECK, 16'(POOL - 1));
      send_item(CMD_CHECK_ALT, 16'h5555);
      send_item(CMD_FREE, 16'h0100);
      wait_all_results();

      // random phases: fill to full, drain to empty, or a mixed stretch
      first_phase = 1'b1;
      while (sent_count < ITEMS) begin
         kind = first_phase ? PH_FILL : phase_kind_type'($urandom_range(0, 2));
         first_phase = 1'b0;
         case (kind)
            PH_FILL: begin
               extra = 0;
               while (extra < 6) begin
                  if (pool_shadow.live_total >= POOL) extra++;
                  random_request(80, 5, 70);
               end
            end
            PH_EMPTY: begin
               while (pool_shadow.live_total != 0) random_request(5, 80, 85);
               repeat ($urandom_range(2, 6)) random_request(10, 60, 50);
               wait_all_results();
            end
            default: begin
               len       = $urandom_range(20, 150);
               alloc_pct = $urandom_range(20, 70);
               repeat (len) random_request(alloc_pct, 25, 60);
            end
         endcase
      end

      // drain and let the block settle
      wait_all_results();
      repeat (20) @(posedge clock);
      if (pool_shadow.fail_count == 0 && pool_shadow.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: dense_handle_allocator_core.f
rtl/hda_pkg.sv
rtl/hda_if.sv
rtl/hda_ram.sv
rtl/hda_rsp_stage.sv
rtl/dense_handle_allocator_core.sv
verif/tb_dense_handle_allocator_core.sv
